FILE: design/fpa_pkg.sv
// Package with widths, opcodes, pipeline types and the saturation helper of the ALU.
`timescale 1ns / 1ps
package fpa_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 8;
    localparam int OP_BITS   = 4;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;
    localparam int MAG_BITS  = PROD_BITS + 1;
    localparam int RND_IDX   = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;

    localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_MUL    = 4'd2,
        OP_DIV    = 4'd3,
        OP_GT     = 4'd4,
        OP_GE     = 4'd5,
        OP_LT     = 4'd6,
        OP_LE     = 4'd7,
        OP_EQ     = 4'd8,
        OP_NE     = 4'd9,
        OP_MIN    = 4'd10,
        OP_MAX    = 4'd11,
        OP_INC    = 4'd12,
        OP_DEC    = 4'd13,
        OP_TO_INT = 4'd14
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [WORD_BITS-1:0] value;
        logic                 cmp;
        logic                 ovf;
        logic                 dz;
        logic                 neg;
        logic [PROD_BITS-1:0] prod;
        logic [WORD_BITS-1:0] dvs;
        logic [WORD_BITS-1:0] rem;
        logic [NUM_BITS-1:0]  num;
        logic [NUM_BITS-1:0]  quo;
    } t_stage;

    typedef struct packed {
        logic [WORD_BITS-1:0] value;
        logic                 ovf;
    } t_packed;

    function automatic t_packed pack_signed(input logic [MAG_BITS-1:0] mag, input logic neg);
        logic [MAG_BITS-1:0] limit;
        t_packed             res;
        limit = neg ? MAG_BITS'(WORD_MIN) : MAG_BITS'(WORD_MAX);
        if (mag > limit) begin
            res.ovf   = 1'b1;
            res.value = neg ? WORD_MIN : WORD_MAX;
        end else begin
            res.ovf   = 1'b0;
            res.value = neg ? WORD_BITS'(~mag + 1'b1) : mag[WORD_BITS-1:0];
        end
        return res;
    endfunction

endpackage

FILE: design/fixed_point_alu_core.sv
// Top level of the pipelined signed fixed-point ALU.
`timescale 1ns / 1ps
// Signed fixed-point ALU on raw two's-complement words, fully pipelined: one transaction
// can enter in every cycle in which the pipeline advances and passes the input register,
// the restoring divider's stages, which resolve one quotient bit per stage, and the output
// register. All opcodes pass the same pipeline, so results leave in order.
// The whole pipeline advances when the output register is empty or being taken.
module fixed_point_alu_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [fpa_pkg::OP_BITS-1:0]         i_opcode,
    input  logic signed [fpa_pkg::WORD_BITS-1:0] i_operand_a,
    input  logic signed [fpa_pkg::WORD_BITS-1:0] i_operand_b,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [fpa_pkg::WORD_BITS-1:0] o_result_value,
    output logic                                o_compare_true,
    output logic                                o_overflow,
    output logic                                o_div_by_zero
);
    import fpa_pkg::*;

    logic                 advance;
    logic                 r_a_valid;
    t_op                  r_a_op;
    logic [WORD_BITS-1:0] r_a_a;
    logic [WORD_BITS-1:0] r_a_b;
    logic [NUM_BITS:0]    r_valid;
    t_stage               r_pipe [NUM_BITS+1];
    t_stage               n_pipe [NUM_BITS+1];
    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_out_value;
    logic                 r_out_cmp;
    logic                 r_out_ovf;
    logic                 r_out_dz;
    logic [WORD_BITS-1:0] n_out_value;
    logic                 n_out_ovf;

    logic [WORD_BITS:0]   sum_ab;
    logic [WORD_BITS:0]   dif_ab;
    logic [WORD_BITS:0]   inc_a;
    logic [WORD_BITS:0]   dec_a;
    logic                 a_gt_b;
    logic                 b_gt_a;
    logic [WORD_BITS-1:0] mag_a;
    logic [WORD_BITS-1:0] mag_b;
    logic [WORD_BITS:0]   div_rr  [NUM_BITS];
    logic                 div_ge  [NUM_BITS];
    logic [MAG_BITS-1:0]  fin_mag;
    logic                 fin_rnd;
    t_packed              fin_pack;

    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = advance;

    always_comb begin
        sum_ab = {r_a_a[WORD_BITS-1], r_a_a} + {r_a_b[WORD_BITS-1], r_a_b};
        dif_ab = {r_a_a[WORD_BITS-1], r_a_a} - {r_a_b[WORD_BITS-1], r_a_b};
        inc_a  = {r_a_a[WORD_BITS-1], r_a_a} + (WORD_BITS+1)'(1);
        dec_a  = {r_a_a[WORD_BITS-1], r_a_a} - (WORD_BITS+1)'(1);
        a_gt_b = $signed(r_a_a) > $signed(r_a_b);
        b_gt_a = $signed(r_a_b) > $signed(r_a_a);
        mag_a  = r_a_a[WORD_BITS-1] ? (~r_a_a + 1'b1) : r_a_a;
        mag_b  = r_a_b[WORD_BITS-1] ? (~r_a_b + 1'b1) : r_a_b;

        n_pipe[0]       = '0;
        n_pipe[0].op    = r_a_op;
        n_pipe[0].neg   = r_a_a[WORD_BITS-1] ^ r_a_b[WORD_BITS-1];
        n_pipe[0].prod  = PROD_BITS'(mag_a) * PROD_BITS'(mag_b);
        n_pipe[0].dvs   = mag_b;
        n_pipe[0].num   = NUM_BITS'(mag_a) << FRAC_BITS;

        case (r_a_op)
            OP_ADD: begin
                n_pipe[0].ovf   = sum_ab[WORD_BITS] != sum_ab[WORD_BITS-1];
                n_pipe[0].value = n_pipe[0].ovf ? (sum_ab[WORD_BITS] ? WORD_MIN : WORD_MAX)
                                                : sum_ab[WORD_BITS-1:0];
            end
            OP_SUB: begin
                n_pipe[0].ovf   = dif_ab[WORD_BITS] != dif_ab[WORD_BITS-1];
                n_pipe[0].value = n_pipe[0].ovf ? (dif_ab[WORD_BITS] ? WORD_MIN : WORD_MAX)
                                                : dif_ab[WORD_BITS-1:0];
            end
            OP_INC: begin
                n_pipe[0].ovf   = inc_a[WORD_BITS] != inc_a[WORD_BITS-1];
                n_pipe[0].value = n_pipe[0].ovf ? WORD_MAX : inc_a[WORD_BITS-1:0];
            end
            OP_DEC: begin
                n_pipe[0].ovf   = dec_a[WORD_BITS] != dec_a[WORD_BITS-1];
                n_pipe[0].value = n_pipe[0].ovf ? WORD_MIN : dec_a[WORD_BITS-1:0];
            end
            OP_DIV: begin
                if (r_a_b == '0) begin
                    n_pipe[0].dz    = 1'b1;
                    n_pipe[0].value = r_a_a[WORD_BITS-1] ? WORD_MIN : WORD_MAX;
                end
            end
            OP_GT:     n_pipe[0].cmp = a_gt_b;
            OP_GE:     n_pipe[0].cmp = !b_gt_a;
            OP_LT:     n_pipe[0].cmp = b_gt_a;
            OP_LE:     n_pipe[0].cmp = !a_gt_b;
            OP_EQ:     n_pipe[0].cmp = r_a_a == r_a_b;
            OP_NE:     n_pipe[0].cmp = r_a_a != r_a_b;
            OP_MIN:    n_pipe[0].value = b_gt_a ? r_a_a : r_a_b;
            OP_MAX:    n_pipe[0].value = a_gt_b ? r_a_a : r_a_b;
            OP_TO_INT: n_pipe[0].value = WORD_BITS'($signed(r_a_a) >>> FRAC_BITS);
            default:   n_pipe[0].value = '0;
        endcase

        for (int k = 0; k < NUM_BITS; k++) begin
            div_rr[k]         = {r_pipe[k].rem, r_pipe[k].num[NUM_BITS-1]};
            div_ge[k]         = div_rr[k] >= {1'b0, r_pipe[k].dvs};
            n_pipe[k+1]       = r_pipe[k];
            n_pipe[k+1].rem   = div_ge[k] ? WORD_BITS'(div_rr[k] - {1'b0, r_pipe[k].dvs})
                                          : div_rr[k][WORD_BITS-1:0];
            n_pipe[k+1].num   = r_pipe[k].num << 1;
            n_pipe[k+1].quo   = {r_pipe[k].quo[NUM_BITS-2:0], div_ge[k]};
        end
    end

    always_comb begin
        fin_rnd = 1'b0;
        fin_mag = '0;
        if (r_pipe[NUM_BITS].op == OP_MUL) begin
            fin_rnd = (FRAC_BITS > 0) && r_pipe[NUM_BITS].prod[RND_IDX];
            fin_mag = MAG_BITS'(r_pipe[NUM_BITS].prod >> FRAC_BITS) + MAG_BITS'(fin_rnd);
        end else begin
            fin_rnd = {r_pipe[NUM_BITS].rem, 1'b0} >= {1'b0, r_pipe[NUM_BITS].dvs};
            fin_mag = MAG_BITS'(r_pipe[NUM_BITS].quo) + MAG_BITS'(fin_rnd);
        end
        fin_pack = pack_signed(fin_mag, r_pipe[NUM_BITS].neg);
        n_out_value = r_pipe[NUM_BITS].value;
        n_out_ovf   = r_pipe[NUM_BITS].ovf;
        if (r_pipe[NUM_BITS].op == OP_MUL ||
            (r_pipe[NUM_BITS].op == OP_DIV && !r_pipe[NUM_BITS].dz)) begin
            n_out_value = fin_pack.value;
            n_out_ovf   = fin_pack.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_a_valid   <= i_in_valid;
            r_valid     <= {r_valid[NUM_BITS-1:0], r_a_valid};
            r_out_valid <= r_valid[NUM_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_op      <= t_op'(i_opcode);
            r_a_a       <= i_operand_a;
            r_a_b       <= i_operand_b;
            for (int k = 0; k <= NUM_BITS; k++) begin
                r_pipe[k] <= n_pipe[k];
            end
            r_out_value <= n_out_value;
            r_out_cmp   <= r_pipe[NUM_BITS].cmp;
            r_out_ovf   <= n_out_ovf;
            r_out_dz    <= r_pipe[NUM_BITS].dz;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_compare_true = r_out_cmp;
    assign o_overflow     = r_out_ovf;
    assign o_div_by_zero  = r_out_dz;

endmodule

FILE: design/fpa_checker.sv
// Port-level checker for the fixed-point ALU and its bind to the top level.
`timescale 1ns / 1ps
module fpa_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic signed [fpa_pkg::WORD_BITS-1:0] o_result_value,
    input logic                                o_compare_true,
    input logic                                o_overflow,
    input logic                                o_div_by_zero
);
    import fpa_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_value))
        else $error("result transaction changed while stalled");

    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_compare_true |-> !o_overflow && !o_div_by_zero &&
        o_result_value == '0)
        else $error("comparison result carries other fields");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_overflow && o_div_by_zero))
        else $error("overflow and divide by zero both set");

    a_sat_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_overflow || o_div_by_zero) |->
        o_result_value == $signed(WORD_MIN) || o_result_value == $signed(WORD_MAX))
        else $error("flagged result is not a saturated word");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind fixed_point_alu_core fpa_checker u_fpa_checker (.*);

FILE: sim/tb_top.sv
// Self-checking testbench of the pipelined signed fixed-point ALU.
`timescale 1ns / 1ps
import fpa_pkg::*;

typedef struct {
    logic [WORD_BITS-1:0] value;
    logic                 cmp;
    logic                 ovf;
    logic                 dz;
} t_alu_result;

class alu_scoreboard;
    t_alu_result pending[$];
    int          errors;
    int          checked;

    function new();
        errors  = 0;
        checked = 0;
    endfunction

    function automatic t_alu_result saturate(logic [MAG_BITS-1:0] mag, logic neg);
        t_alu_result r;
        logic [MAG_BITS-1:0] lim;
        r.cmp = 1'b0;
        r.dz  = 1'b0;
        lim = neg ? MAG_BITS'(WORD_MIN) : MAG_BITS'(WORD_MAX);
        if (mag > lim) begin
            r.ovf   = 1'b1;
            r.value = neg ? WORD_MIN : WORD_MAX;
        end else begin
            r.ovf   = 1'b0;
            r.value = neg ? WORD_BITS'(-mag) : mag[WORD_BITS-1:0];
        end
        return r;
    endfunction

    function automatic t_alu_result compute(logic [3:0] op, logic signed [WORD_BITS-1:0] a,
                                            logic signed [WORD_BITS-1:0] b);
        t_alu_result r;
        logic signed [WORD_BITS+1:0] s;
        logic [MAG_BITS-1:0] ma, mb, mag, q, rm;
        logic neg;
        r = '{default: 0};
        ma  = a < 0 ? MAG_BITS'(-65'(a)) : MAG_BITS'(a);
        mb  = b < 0 ? MAG_BITS'(-65'(b)) : MAG_BITS'(b);
        neg = (a < 0) != (b < 0);
        case (op)
            OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
                if (op == OP_ADD) s = a + b;
                else if (op == OP_SUB) s = a - b;
                else if (op == OP_INC) s = a + 1;
                else s = a - 1;
                if (s > $signed({3'b0, WORD_MAX})) begin
                    r.value = WORD_MAX;
                    r.ovf   = 1'b1;
                end else if (s < -$signed({3'b0, WORD_MIN})) begin
                    r.value = WORD_MIN;
                    r.ovf   = 1'b1;
                end else begin
                    r.value = s[WORD_BITS-1:0];
                end
            end
            OP_MUL: begin
                mag = ma * mb;
                if (FRAC_BITS > 0)
                    mag = (mag >> FRAC_BITS) + mag[RND_IDX];
                r = saturate(mag, neg);
            end
            OP_DIV: begin
                if (b == 0) begin
                    r.dz    = 1'b1;
                    r.value = a < 0 ? WORD_MIN : WORD_MAX;
                end else begin
                    q  = (ma << FRAC_BITS) / mb;
                    rm = (ma << FRAC_BITS) % mb;
                    if (rm >= mb - rm) q = q + 1;
                    r = saturate(q, neg);
                end
            end
            OP_GT: r.cmp = a > b;
            OP_GE: r.cmp = a >= b;
            OP_LT: r.cmp = a < b;
            OP_LE: r.cmp = a <= b;
            OP_EQ: r.cmp = a == b;
            OP_NE: r.cmp = a != b;
            OP_MIN: r.value = (a < b) ? a : b;
            OP_MAX: r.value = (a > b) ? a : b;
            OP_TO_INT: r.value = a >>> FRAC_BITS;
            default: ;
        endcase
        return r;
    endfunction

    function void note_input(logic [3:0] op, logic [WORD_BITS-1:0] a, logic [WORD_BITS-1:0] b);
        pending.push_back(compute(op, a, b));
    endfunction

    function void check_result(logic [WORD_BITS-1:0] v, logic c, logic o, logic d);
        t_alu_result e;
        if (pending.size() == 0) begin
            $display("%0t: result with none expected: value %h", $time, v);
            errors++;
            return;
        end
        e = pending.pop_front();
        checked++;
        if (v !== e.value || c !== e.cmp || o !== e.ovf || d !== e.dz) begin
            $display("%0t: mismatch expected value %h cmp %b ovf %b dz %b", $time,
                     e.value, e.cmp, e.ovf, e.dz);
            $display("%0t:          actual   value %h cmp %b ovf %b dz %b", $time,
                     v, c, o, d);
            errors++;
        end
    endfunction
endclass

module tb_top;
    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic [OP_BITS-1:0]          i_opcode;
    logic signed [WORD_BITS-1:0] i_operand_a;
    logic signed [WORD_BITS-1:0] i_operand_b;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic signed [WORD_BITS-1:0] o_result_value;
    logic                        o_compare_true;
    logic                        o_overflow;
    logic                        o_div_by_zero;

    alu_scoreboard sb;
    int            cycles;

    localparam int LIMIT = 400000;

    fixed_point_alu_core uut (.*);

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && i_in_valid && o_in_ready)
            sb.note_input(i_opcode, i_operand_a, i_operand_b);
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_result_value, o_compare_true, o_overflow, o_div_by_zero);
        if (cycles > LIMIT) begin
            $display("tb_top: timeout after %0d cycles", cycles);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [WORD_BITS-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return WORD_MAX - $urandom_range(0, 3);
            1: return WORD_MIN + $urandom_range(0, 3);
            2: return $urandom_range(0, 3);
            3: return -$urandom_range(1, 3);
            4: return $signed($urandom) >>> $urandom_range(8, 24);
            default: return $urandom;
        endcase
    endfunction

    task automatic send(logic [3:0] op, logic [WORD_BITS-1:0] a, logic [WORD_BITS-1:0] b);
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_gapped(logic [3:0] op, logic [WORD_BITS-1:0] a,
                               logic [WORD_BITS-1:0] b, bit burst);
        int g;
        g = burst ? 0 : pick_gap();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        send(op, a, b);
    endtask

    initial begin
        bit quiet;
        quiet = 1'b0;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 199) == 0) quiet = !quiet;
            i_out_ready <= quiet ? 1'b1 : (pick_gap() == 0);
        end
    end

    initial begin
        logic [3:0] op;
        bit         burst;
        sb          = new();
        cycles      = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_opcode    = '0;
        i_operand_a = '0;
        i_operand_b = '0;
        i_out_ready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(OP_ADD, WORD_MAX, 1);
        send(OP_ADD, WORD_MIN, WORD_MIN);
        send(OP_SUB, 0, WORD_MIN);
        send(OP_SUB, WORD_MIN, 1);
        send(OP_MUL, WORD_MAX, WORD_MAX);
        send(OP_MUL, 32'h180, 32'hFFFFFE80);
        send(OP_MUL, 1, 32'h80);
        send(OP_MUL, -1, 32'h80);
        send(OP_DIV, 32'h100, 0);
        send(OP_DIV, WORD_MIN, 0);
        send(OP_DIV, WORD_MIN, 1);
        send(OP_DIV, 32'h100, 32'h300);
        send(OP_DIV, -32'sh100, 32'h200);
        for (int k = OP_GT; k <= OP_NE; k++) send(k[3:0], WORD_MIN, WORD_MAX);
        send(OP_EQ, 5, 5);
        send(OP_MIN, 7, 7);
        send(OP_MAX, WORD_MIN, WORD_MAX);
        send(OP_INC, WORD_MAX, 0);
        send(OP_DEC, WORD_MIN, 0);
        send(OP_TO_INT, WORD_MIN, 0);
        send(4'd15, WORD_MAX, WORD_MAX);

        burst = 1'b0;
        for (int n = 0; n < 950; n++) begin
            if ($urandom_range(0, 49) == 0) burst = !burst;
            op = 4'($urandom_range(0, 15));
            send_gapped(op, pick_word(), ($urandom_range(0, 19) == 0) ? '0 : pick_word(),
                        burst);
        end
        i_in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("tb_top: %0d results checked over all opcodes, with random stalls on both sides",
                 sb.checked);
        if (sb.errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule

FILE: files.f
design/fpa_pkg.sv
design/fixed_point_alu_core.sv
design/fpa_checker.sv
sim/tb_top.sv
